// ----- design/image_type_and_size_parser_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the image type and size parser
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef IMAGE_TYPE_AND_SIZE_PARSER_MACROS_SVH
`define IMAGE_TYPE_AND_SIZE_PARSER_MACROS_SVH

// plain property, checked every edge
`define ITSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// same-cycle implication
`define ITSP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ITSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/itsp_pkg.sv -----
// ---------------------------------------------------------------------------
// itsp_pkg
// Types, codes and constants shared by the image type and size parser.
// ---------------------------------------------------------------------------
`default_nettype none

package itsp_pkg;

   // image type codes
   localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
   localparam logic [1:0] TYPE_JPEG    = 2'd1;
   localparam logic [1:0] TYPE_GIF     = 2'd2;
   localparam logic [1:0] TYPE_PNG     = 2'd3;

   // byte counter saturates here
   localparam logic [4:0] POS_SAT = 5'd24;

   // JPEG markers
   localparam logic [7:0]  JPEG_FILL = 8'hFF;
   localparam logic [7:0]  JPEG_SOF0 = 8'hC0;
   localparam logic [7:0]  JPEG_SOF3 = 8'hC3;
   localparam logic [7:0]  JPEG_EOI  = 8'hD9;
   localparam logic [7:0]  JPEG_SOS  = 8'hDA;
   localparam logic [15:0] JPEG_SOI_PAIR = 16'hFFD8;
   localparam logic [15:0] JPEG_EOI_PAIR = 16'hFFD9;

   // GIF block introducers
   localparam logic [7:0]  GIF_EXT   = 8'h21;
   localparam logic [7:0]  GIF_IMAGE = 8'h2C;
   localparam logic [47:0] GIF87A    = 48'h474946383761;
   localparam logic [47:0] GIF89A    = 48'h474946383961;

   // PNG signature
   localparam logic [63:0] PNG_SIG = 64'h89504E470D0A1A0A;

   // per-word control into the format parsers
   typedef struct packed {
      logic step;     // a byte is consumed this cycle
      logic restart;  // last byte of the file: return to reset state
   } step_type;

   // parser outcome after the current byte
   typedef struct packed {
      logic        found;
      logic        failed;
      logic [31:0] width;
      logic [31:0] height;
   } dims_type;

   function automatic logic [1:0] prefix_kind(input logic [63:0] sig);
      logic [1:0] kind;
      kind = TYPE_UNKNOWN;
      if (sig[63:48] == JPEG_SOI_PAIR) begin
         kind = TYPE_JPEG;
      end else if (sig[63:16] == GIF87A || sig[63:16] == GIF89A) begin
         kind = TYPE_GIF;
      end else if (sig == PNG_SIG) begin
         kind = TYPE_PNG;
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

// ----- design/itsp_jpeg_parser.sv -----
// ---------------------------------------------------------------------------
// itsp_jpeg_parser
// Marker walker for JPEG: skips segments, reads height and width from SOF0 to SOF3.
// ---------------------------------------------------------------------------
`default_nettype none

module itsp_jpeg_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire itsp_pkg::step_type ctrl,
   input  wire logic [7:0]         file_byte,
   output itsp_pkg::dims_type      dims
);

   localparam logic [2:0] PH_SEEK = 3'd0;
   localparam logic [2:0] PH_MARK = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_SKIP = 3'd3;
   localparam logic [2:0] PH_SOF  = 3'd4;
   localparam logic [2:0] PH_IDLE = 3'd5;

   logic [2:0]  phase_ff, phase_upd, phase_in;
   logic [15:0] skip_ff, skip_upd, skip_in;
   logic [15:0] acc_ff, acc_upd, acc_in;
   logic [15:0] w_ff, w_upd, w_in;
   logic [15:0] h_ff, h_upd, h_in;
   logic        found_ff, found_upd, found_in;
   logic        failed_ff, failed_upd, failed_in;
   logic [15:0] acc_shift;
   logic [2:0]  sof_idx;

   assign acc_shift = {acc_ff[7:0], file_byte};
   assign sof_idx   = 3'd7 - skip_ff[2:0];

   always_comb begin
      phase_upd  = phase_ff;
      skip_upd   = skip_ff;
      acc_upd    = acc_ff;
      w_upd      = w_ff;
      h_upd      = h_ff;
      found_upd  = found_ff;
      failed_upd = failed_ff;
      if (ctrl.step) begin
         unique case (phase_ff)
            PH_SEEK: begin
               if (file_byte == itsp_pkg::JPEG_FILL) phase_upd = PH_MARK;
            end
            PH_MARK: begin
               if (file_byte != itsp_pkg::JPEG_FILL) begin
                  acc_upd = '0;
                  if (file_byte == itsp_pkg::JPEG_SOS || file_byte == itsp_pkg::JPEG_EOI) begin
                     failed_upd = 1'b1;
                     phase_upd  = PH_IDLE;
                  end else if (file_byte >= itsp_pkg::JPEG_SOF0 &&
                               file_byte <= itsp_pkg::JPEG_SOF3) begin
                     skip_upd  = 16'd7;
                     phase_upd = PH_SOF;
                  end else begin
                     skip_upd  = 16'd2;
                     phase_upd = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               acc_upd = acc_shift;
               if (skip_ff > 16'd1) begin
                  skip_upd = skip_ff - 16'd1;
               end else if (acc_shift < 16'd2) begin
                  failed_upd = 1'b1;
                  phase_upd  = PH_IDLE;
               end else if (acc_shift == 16'd2) begin
                  skip_upd  = '0;
                  phase_upd = PH_SEEK;
               end else begin
                  skip_upd  = acc_shift - 16'd2;
                  phase_upd = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (skip_ff > 16'd1) begin
                  skip_upd = skip_ff - 16'd1;
               end else begin
                  skip_upd  = '0;
                  phase_upd = PH_SEEK;
               end
            end
            PH_SOF: begin
               acc_upd = acc_shift;
               if (sof_idx == 3'd4) h_upd = acc_shift;
               if (skip_ff > 16'd1) begin
                  skip_upd = skip_ff - 16'd1;
               end else begin
                  skip_upd  = '0;
                  w_upd     = acc_shift;
                  found_upd = 1'b1;
                  phase_upd = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (ctrl.restart) begin
         phase_in  = PH_SEEK;
         skip_in   = '0;
         acc_in    = '0;
         w_in      = '0;
         h_in      = '0;
         found_in  = 1'b0;
         failed_in = 1'b0;
      end else begin
         phase_in  = phase_upd;
         skip_in   = skip_upd;
         acc_in    = acc_upd;
         w_in      = w_upd;
         h_in      = h_upd;
         found_in  = found_upd;
         failed_in = failed_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEEK;
         skip_ff   <= '0;
         acc_ff    <= '0;
         w_ff      <= '0;
         h_ff      <= '0;
         found_ff  <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         skip_ff   <= skip_in;
         acc_ff    <= acc_in;
         w_ff      <= w_in;
         h_ff      <= h_in;
         found_ff  <= found_in;
         failed_ff <= failed_in;
      end
   end

   // outcome including the byte of this cycle
   assign dims.found  = found_upd;
   assign dims.failed = failed_upd;
   assign dims.width  = {16'd0, w_upd};
   assign dims.height = {16'd0, h_upd};

endmodule

`default_nettype wire

// ----- design/itsp_gif_parser.sv -----
// ---------------------------------------------------------------------------
// itsp_gif_parser
// GIF block walker: color table, extensions, image descriptor size fields.
// ---------------------------------------------------------------------------
`default_nettype none

module itsp_gif_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire itsp_pkg::step_type ctrl,
   input  wire logic [7:0]         file_byte,
   input  wire logic [4:0]         byte_pos,
   output itsp_pkg::dims_type      dims
);

   localparam logic [2:0] PH_HDR   = 3'd0;
   localparam logic [2:0] PH_TABLE = 3'd1;
   localparam logic [2:0] PH_BLOCK = 3'd2;
   localparam logic [2:0] PH_LABEL = 3'd3;
   localparam logic [2:0] PH_COUNT = 3'd4;
   localparam logic [2:0] PH_SUB   = 3'd5;
   localparam logic [2:0] PH_DESC  = 3'd6;
   localparam logic [2:0] PH_IDLE  = 3'd7;

   logic [2:0]  phase_ff, phase_upd, phase_in;
   logic [9:0]  skip_ff, skip_upd, skip_in;   // table skip tops out at 768
   logic [31:0] acc_ff, acc_upd, acc_in;
   logic [15:0] w_ff, w_upd, w_in;
   logic [15:0] h_ff, h_upd, h_in;
   logic        found_ff, found_upd, found_in;
   logic        failed_ff, failed_upd, failed_in;
   logic [3:0]  desc_idx;
   logic [31:0] acc_desc;

   assign desc_idx = 4'd9 - skip_ff[3:0];
   assign acc_desc = (desc_idx >= 4'd4 && desc_idx <= 4'd7) ?
                     {file_byte, acc_ff[31:8]} : acc_ff;

   always_comb begin
      phase_upd  = phase_ff;
      skip_upd   = skip_ff;
      acc_upd    = acc_ff;
      w_upd      = w_ff;
      h_upd      = h_ff;
      found_upd  = found_ff;
      failed_upd = failed_ff;
      if (ctrl.step) begin
         unique case (phase_ff)
            PH_HDR: begin
               // logical screen flags at byte 10, decision at byte 12
               if (byte_pos == 5'd10) acc_upd = {24'd0, file_byte};
               if (byte_pos == 5'd12) begin
                  if (acc_ff[7]) begin
                     skip_upd  = 10'd3 << (4'(acc_ff[2:0]) + 4'd1);
                     phase_upd = PH_TABLE;
                  end else begin
                     phase_upd = PH_BLOCK;
                  end
               end
            end
            PH_TABLE, PH_SUB: begin
               if (skip_ff > 10'd1) begin
                  skip_upd = skip_ff - 10'd1;
               end else begin
                  skip_upd  = '0;
                  phase_upd = (phase_ff == PH_TABLE) ? PH_BLOCK : PH_COUNT;
               end
            end
            PH_BLOCK: begin
               if (file_byte == itsp_pkg::GIF_EXT) begin
                  phase_upd = PH_LABEL;
               end else if (file_byte == itsp_pkg::GIF_IMAGE) begin
                  skip_upd  = 10'd9;
                  acc_upd   = '0;
                  phase_upd = PH_DESC;
               end else begin
                  failed_upd = 1'b1;
                  phase_upd  = PH_IDLE;
               end
            end
            PH_LABEL: phase_upd = PH_COUNT;
            PH_COUNT: begin
               if (file_byte == 8'd0) begin
                  phase_upd = PH_BLOCK;
               end else begin
                  skip_upd  = {2'd0, file_byte};
                  phase_upd = PH_SUB;
               end
            end
            PH_DESC: begin
               acc_upd = acc_desc;
               if (skip_ff > 10'd1) begin
                  skip_upd = skip_ff - 10'd1;
               end else begin
                  skip_upd  = '0;
                  w_upd     = acc_desc[15:0];
                  h_upd     = acc_desc[31:16];
                  found_upd = 1'b1;
                  phase_upd = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (ctrl.restart) begin
         phase_in  = PH_HDR;
         skip_in   = '0;
         acc_in    = '0;
         w_in      = '0;
         h_in      = '0;
         found_in  = 1'b0;
         failed_in = 1'b0;
      end else begin
         phase_in  = phase_upd;
         skip_in   = skip_upd;
         acc_in    = acc_upd;
         w_in      = w_upd;
         h_in      = h_upd;
         found_in  = found_upd;
         failed_in = failed_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR;
         skip_ff   <= '0;
         acc_ff    <= '0;
         w_ff      <= '0;
         h_ff      <= '0;
         found_ff  <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         skip_ff   <= skip_in;
         acc_ff    <= acc_in;
         w_ff      <= w_in;
         h_ff      <= h_in;
         found_ff  <= found_in;
         failed_ff <= failed_in;
      end
   end

   assign dims.found  = found_upd;
   assign dims.failed = failed_upd;
   assign dims.width  = {16'd0, w_upd};
   assign dims.height = {16'd0, h_upd};

endmodule

`default_nettype wire

// ----- design/image_type_and_size_parser.sv -----
// ---------------------------------------------------------------------------
// image_type_and_size_parser
// Streams a file byte by byte and reports image type, width and height.
// ---------------------------------------------------------------------------
// Feed the file one byte per word on req_, marking the final byte with
// req_tlast. One result word comes out on rsp_ for every file, after its
// last byte: the type (JPEG, GIF or PNG or unknown) and the pixel width and
// height, with size_ok set when both dimensions were found. A byte is taken
// every cycle while the input does not stall: each word goes through an input
// register, the parser logic and a result register, which drives rsp_; the
// next file may follow at once. Input stalls only when a finished result is
// still held on rsp_ and the next last byte is waiting to replace it. The GIF
// parser and the PNG field capture run on every byte from the start of the
// file, the JPEG parser from the third byte on, side by side; the 8-byte
// signature picks which one answers. Files under 8 bytes, JPEG without an
// FF D9 tail, and bad or truncated headers give 0 x 0 with size_ok clear.
// All state returns to reset after each file.
// ---------------------------------------------------------------------------
`default_nettype none

`include "image_type_and_size_parser_macros.svh"

module image_type_and_size_parser (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] file_byte
   input  wire logic        req_tlast,    // last_byte

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,    // [31:0] width, [63:32] height
   output logic [2:0]       rsp_tuser     // [1:0] image_type, [2] size_ok
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;

   // file-level state
   logic [4:0]  pos_ff, pos_in;
   logic [63:0] sig_ff, sig_in;
   logic [15:0] tail_ff, tail_in;

   // PNG fields are fixed offsets, captured here
   logic [31:0] png_acc_ff, png_acc_in, png_acc_shift;
   logic [31:0] png_w_ff, png_w_in;
   logic [31:0] png_h_ff, png_h_in;
   logic        png_found_ff, png_found_upd, png_found_in;
   logic [31:0] png_w_upd, png_h_upd;
   logic        png_window;

   itsp_pkg::step_type jpeg_ctrl, gif_ctrl;
   itsp_pkg::dims_type jpeg_dims, gif_dims, sel_dims;

   logic [1:0] kind, file_type;
   logic       size_ok;
   logic       finish;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_type_ff;
   logic [31:0] rsp_w_ff, rsp_h_ff;
   logic        rsp_ok_ff;

   // a word moves on unless it is a last byte and the result slot is blocked
   assign advance     = in_valid_ff & (~in_last_ff | ~rsp_valid_ff | rsp_tready);
   assign req_tready  = ~in_valid_ff | advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign finish      = advance & in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // signature collects the first 8 bytes, tail keeps the latest two
   assign sig_in  = (pos_ff < 5'd8) ? {sig_ff[55:0], in_byte_ff} : sig_ff;
   assign tail_in = {tail_ff[7:0], in_byte_ff};
   assign pos_in  = (pos_ff < itsp_pkg::POS_SAT) ? pos_ff + 5'd1 : itsp_pkg::POS_SAT;

   // PNG: width in bytes 16..19, height in bytes 20..23, big-endian
   assign png_window    = (pos_ff >= 5'd16) && (pos_ff <= 5'd23);
   assign png_acc_shift = png_window ? {png_acc_ff[23:0], in_byte_ff} : png_acc_ff;
   assign png_w_upd     = (pos_ff == 5'd19) ? png_acc_shift : png_w_ff;
   assign png_h_upd     = (pos_ff == 5'd23) ? png_acc_shift : png_h_ff;
   assign png_found_upd = png_found_ff | (pos_ff == 5'd23);

   assign png_acc_in   = finish ? '0 : png_acc_shift;
   assign png_w_in     = finish ? '0 : png_w_upd;
   assign png_h_in     = finish ? '0 : png_h_upd;
   assign png_found_in = ~finish & png_found_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sig_ff       <= '0;
         tail_ff      <= '0;
         png_acc_ff   <= '0;
         png_w_ff     <= '0;
         png_h_ff     <= '0;
         png_found_ff <= 1'b0;
      end else if (finish) begin
         pos_ff       <= '0;
         sig_ff       <= '0;
         tail_ff      <= '0;
         png_acc_ff   <= png_acc_in;
         png_w_ff     <= png_w_in;
         png_h_ff     <= png_h_in;
         png_found_ff <= png_found_in;
      end else if (advance) begin
         pos_ff       <= pos_in;
         sig_ff       <= sig_in;
         tail_ff      <= tail_in;
         png_acc_ff   <= png_acc_in;
         png_w_ff     <= png_w_in;
         png_h_ff     <= png_h_in;
         png_found_ff <= png_found_in;
      end
   end

   // JPEG walk starts after FF D8; GIF header fields sit past the signature
   assign jpeg_ctrl.step    = advance & (pos_ff >= 5'd2);
   assign jpeg_ctrl.restart = finish;
   assign gif_ctrl.step     = advance;
   assign gif_ctrl.restart  = finish;

   itsp_jpeg_parser u_jpeg (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (jpeg_ctrl),
      .file_byte (in_byte_ff),
      .dims      (jpeg_dims)
   );

   itsp_gif_parser u_gif (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (gif_ctrl),
      .file_byte (in_byte_ff),
      .byte_pos  (pos_ff),
      .dims      (gif_dims)
   );

   // result for the file ending on this byte
   always_comb begin
      kind      = itsp_pkg::prefix_kind(sig_in);
      file_type = itsp_pkg::TYPE_UNKNOWN;
      if (pos_ff >= 5'd7) begin
         if (kind == itsp_pkg::TYPE_JPEG) begin
            file_type = (tail_in == itsp_pkg::JPEG_EOI_PAIR) ?
                        itsp_pkg::TYPE_JPEG : itsp_pkg::TYPE_UNKNOWN;
         end else begin
            file_type = kind;
         end
      end
   end

   always_comb begin
      case (file_type)
         itsp_pkg::TYPE_JPEG: sel_dims = jpeg_dims;
         itsp_pkg::TYPE_GIF:  sel_dims = gif_dims;
         itsp_pkg::TYPE_PNG: begin
            sel_dims.found  = png_found_upd;
            sel_dims.failed = 1'b0;
            sel_dims.width  = png_w_upd;
            sel_dims.height = png_h_upd;
         end
         default:             sel_dims = '0;
      endcase
   end

   assign size_ok = (file_type != itsp_pkg::TYPE_UNKNOWN) & sel_dims.found & ~sel_dims.failed;

   assign rsp_valid_in = finish | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_type_ff <= file_type;
         rsp_w_ff    <= size_ok ? sel_dims.width : 32'd0;
         rsp_h_ff    <= size_ok ? sel_dims.height : 32'd0;
         rsp_ok_ff   <= size_ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_h_ff, rsp_w_ff};
   assign rsp_tuser  = {rsp_ok_ff, rsp_type_ff};

   // a finished file always lands in the result register
   `ITSP_ASSERT_NEXT(a_finish_gives_result, finish, rsp_valid_ff, "result lost after last byte")
   // a new result only ever follows a last byte
   `ITSP_ASSERT_IMPLY(a_no_spurious_result, $rose(rsp_valid_ff), $past(finish), "result without last byte")
   // failed parses report zero dimensions
   `ITSP_ASSERT_IMPLY(a_zero_when_not_ok, rsp_valid_ff && !rsp_ok_ff, rsp_w_ff == 32'd0 && rsp_h_ff == 32'd0, "nonzero size without size_ok")
   // size_ok needs a known type
   `ITSP_ASSERT_IMPLY(a_ok_needs_type, rsp_valid_ff && rsp_ok_ff, rsp_type_ff != itsp_pkg::TYPE_UNKNOWN, "size_ok on unknown type")

endmodule

`default_nettype wire
